@@ design/tgrh_pkg.sv @@
// Shared types and constants for the touch region hit tester.
// No dependencies; imported by every module of the block.
package tgrh_pkg;

  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int FLAGS_W    = 7;
  localparam int LEVEL_W    = 7;
  localparam int THRESH_W   = 8;
  localparam int IN_TDATA_W = 112;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Region flag bit positions
  localparam int F_TAP      = 0;
  localparam int F_SWIPE_LO = 1;
  localparam int F_SWIPE_HI = 4;
  localparam int F_SLIDE    = 5;
  localparam int F_AXIS_Y   = 6;

  localparam int LEVEL_SCALE = 100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  typedef enum logic [2:0] {
    G_NONE  = 3'd0,
    G_TAP   = 3'd1,
    G_LEFT  = 3'd2,
    G_RIGHT = 3'd3,
    G_UP    = 3'd4,
    G_DOWN  = 3'd5,
    G_SLIDE = 3'd6
  } gesture_e;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [SIZE_W-1:0]  h;
    logic [SIZE_W-1:0]  w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } region_t;

endpackage

@@ design/tgrh_table.sv @@
// Region table: one write port, one registered read port.
// Depends on tgrh_pkg for the entry layout.
module tgrh_table #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  tgrh_pkg::region_t    wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output tgrh_pkg::region_t    rd_data_o
);
  import tgrh_pkg::*;

  region_t mem_q [Depth];
  region_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/tgrh_classify.sv @@
// Gesture classifier: squares travel and thresholds on one shared multiplier,
// then compares. Depends on tgrh_pkg for the gesture codes.
module tgrh_classify (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tgrh_pkg::COORD_W-1:0]      down_x_i,
  input  logic [tgrh_pkg::COORD_W-1:0]      down_y_i,
  input  logic [tgrh_pkg::COORD_W-1:0]      lift_x_i,
  input  logic [tgrh_pkg::COORD_W-1:0]      lift_y_i,
  input  logic [tgrh_pkg::THRESH_W-1:0]     swipe_min_i,
  input  logic [tgrh_pkg::THRESH_W-1:0]     tap_max_i,
  output logic                              done_o,
  output tgrh_pkg::gesture_e                gesture_o
);
  import tgrh_pkg::*;

  localparam logic [2:0] STEP_DX     = 3'd0;
  localparam logic [2:0] STEP_DY     = 3'd1;
  localparam logic [2:0] STEP_SW     = 3'd2;
  localparam logic [2:0] STEP_TP     = 3'd3;
  localparam logic [2:0] STEP_DECIDE = 3'd4;

  logic                busy_q, busy_d;
  logic [2:0]          step_q, step_d;
  logic                done_q, done_d;
  logic [COORD_W-1:0]  adx_q, ady_q;
  logic                negx_q, negy_q;
  logic [THRESH_W-1:0] sw_q, tp_q;
  logic [2*COORD_W-1:0] dx2_q, dy2_q;
  logic [2*THRESH_W-1:0] sw2_q, tp2_q;
  gesture_e            gest_q;

  logic [COORD_W-1:0]   mul_a;
  logic [2*COORD_W-1:0] prod;
  logic [2*COORD_W:0]   d2;
  gesture_e             gest_new;

  always_comb begin
    case (step_q)
      STEP_DX: mul_a = adx_q;
      STEP_DY: mul_a = ady_q;
      STEP_SW: mul_a = {{(COORD_W-THRESH_W){1'b0}}, sw_q};
      STEP_TP: mul_a = {{(COORD_W-THRESH_W){1'b0}}, tp_q};
      default: mul_a = '0;
    endcase
  end

  assign prod = {{COORD_W{1'b0}}, mul_a} * {{COORD_W{1'b0}}, mul_a};
  assign d2   = {1'b0, dx2_q} + {1'b0, dy2_q};

  always_comb begin
    if (d2 >= {{(2*COORD_W+1-2*THRESH_W){1'b0}}, sw2_q}) begin
      if (dx2_q >= dy2_q) gest_new = negx_q ? G_LEFT : G_RIGHT;
      else                gest_new = negy_q ? G_UP : G_DOWN;
    end else if (d2 < {{(2*COORD_W+1-2*THRESH_W){1'b0}}, tp2_q}) begin
      gest_new = G_TAP;
    end else begin
      gest_new = G_NONE;
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_DX;
    end else if (busy_q) begin
      if (step_q == STEP_DECIDE) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_DX;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      adx_q  <= (lift_x_i >= down_x_i) ? lift_x_i - down_x_i : down_x_i - lift_x_i;
      ady_q  <= (lift_y_i >= down_y_i) ? lift_y_i - down_y_i : down_y_i - lift_y_i;
      negx_q <= lift_x_i < down_x_i;
      negy_q <= lift_y_i < down_y_i;
      sw_q   <= swipe_min_i;
      tp_q   <= tap_max_i;
    end else if (busy_q) begin
      case (step_q)
        STEP_DX:     dx2_q  <= prod;
        STEP_DY:     dy2_q  <= prod;
        STEP_SW:     sw2_q  <= prod[2*THRESH_W-1:0];
        STEP_TP:     tp2_q  <= prod[2*THRESH_W-1:0];
        STEP_DECIDE: gest_q <= gest_new;
        default: ;
      endcase
    end
  end

  assign done_o    = done_q;
  assign gesture_o = gest_q;

endmodule

@@ design/tgrh_level.sv @@
// Slide level unit: clamps, then a seven-step restoring divide of offset*100
// by the region size. Depends on tgrh_pkg for the entry layout.
module tgrh_level (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  tgrh_pkg::region_t             region_i,
  input  logic [tgrh_pkg::COORD_W-1:0]  lift_x_i,
  input  logic [tgrh_pkg::COORD_W-1:0]  lift_y_i,
  output logic                          done_o,
  output logic [tgrh_pkg::LEVEL_W-1:0]  level_o
);
  import tgrh_pkg::*;

  localparam int NUM_W = SIZE_W + 2;
  localparam int REM_W = SIZE_W + LEVEL_W;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [2:0]       cnt_q;
  logic [REM_W-1:0] rem_q, dsr_q;
  logic [LEVEL_W-1:0] quo_q;

  logic [NUM_W-1:0]  num;
  logic [SIZE_W-1:0] den;
  logic              nonpos, saturate, take;
  logic [REM_W-1:0]  scaled;

  // Offset from the low end of the slide axis; y runs bottom-up.
  always_comb begin
    if (region_i.flags[F_AXIS_Y]) begin
      num = {3'b0, region_i.y} + {2'b0, region_i.h} - {3'b0, lift_y_i};
      den = region_i.h;
    end else begin
      num = {3'b0, lift_x_i} - {3'b0, region_i.x};
      den = region_i.w;
    end
  end

  assign nonpos   = num[NUM_W-1] || (num == '0);
  assign saturate = num >= {2'b0, den};
  assign scaled   = {{LEVEL_W{1'b0}}, num[SIZE_W-1:0]} * REM_W'(LEVEL_SCALE);
  assign take     = rem_q >= dsr_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      if (nonpos || saturate) done_d = 1'b1;
      else                    busy_d = 1'b1;
    end else if (busy_q && cnt_q == 3'd0) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= scaled;
      dsr_q <= {1'b0, den, {(LEVEL_W-1){1'b0}}};
      cnt_q <= 3'(LEVEL_W - 1);
      if (nonpos)        quo_q <= '0;
      else if (saturate) quo_q <= LEVEL_MAX;
      else               quo_q <= '0;
    end else if (busy_q) begin
      if (take) rem_q <= rem_q - dsr_q;
      quo_q <= {quo_q[LEVEL_W-2:0], take};
      dsr_q <= dsr_q >> 1;
      cnt_q <= cnt_q - 3'd1;
    end
  end

  assign done_o  = done_q;
  assign level_o = quo_q;

endmodule

@@ design/touch_gesture_region_hit.sv @@
// Top level of the touch region hit tester: table, classifier, level unit
// and the search sequencer. Depends on tgrh_pkg and all tgrh_* modules.
//
// Usage. Items enter on the s_axis channel; tuser says what the item is
// (0 stores one region entry, 1 classifies a touch). A region store writes
// the table in the cycle of its transfer and gives no result. A touch item
// gives exactly one result transfer on m_axis. Registers (region count,
// swipe and tap thresholds) are written over the cfg channel, which is
// always ready; write them only while no touch is in flight.
// A touch with n = min(region_count, MAX_REGIONS) goes through classification
// on the shared squaring multiplier, the down-point scan of n entries (one
// table read per cycle), another scan at the lift point for a swipe that
// found no owner, the slide level divider for a slide owner, and a load of
// the output register. The table's single read port sets the scan rate.
// One touch is worked on at a time. Reset clears control state and
// registers to their defaults; the table itself holds garbage until entries
// are written. When the receiver stalls the finished result waits in the
// output register, and the block still takes the next item; a following
// touch holds in its last step until the output register frees up.
module touch_gesture_region_hit #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [3:0] region_index, [15:4] rect_x, [27:16] rect_y, [40:28] rect_w,
  // [53:41] rect_h, [60:54] region_flags, [72:61] down_x, [84:73] down_y,
  // [96:85] lift_x, [108:97] lift_y, [111:109] zero
  input  logic [tgrh_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [0] req_type
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [3:0] hit_region, [6:4] gesture, [13:7] slide_level, [15:14] zero
  output logic [tgrh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // [0] hit
  output logic                                 m_axis_tuser_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tgrh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tgrh_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import tgrh_pkg::*;

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [6:0] MAX_R7 = 7'(MAX_REGIONS);

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX      = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TOUCH = 1'b1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLS  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LVL  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  // Configuration registers
  logic [4:0]          region_count_q;
  logic [THRESH_W-1:0] swipe_min_q, tap_max_q;

  // Sequencer state
  logic [2:0]     state_q, state_d;
  logic           pass_q, pass_d;
  logic [CW-1:0]  issue_q, issue_d;
  logic           chk_v_q, chk_v_d;
  logic [AW-1:0]  chk_idx_q, chk_idx_d;
  gesture_e       gest_q, gest_d;

  // Pending result and output register
  logic               res_hit_q, res_hit_d;
  logic [AW-1:0]      res_idx_q, res_idx_d;
  gesture_e           res_gest_q, res_gest_d;
  logic [LEVEL_W-1:0] res_lvl_q, res_lvl_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;
  logic                   m_tuser_q, m_tuser_d;

  // Touch points of the item in flight
  logic [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;

  logic s_fire;
  logic [3:0]         in_index;
  region_t            in_region;
  logic [COORD_W-1:0] in_down_x, in_down_y, in_lift_x, in_lift_y;
  logic               wr_en;
  logic [6:0]         n7;
  logic [CW-1:0]      n;

  logic               rd_en;
  region_t            rd_data;
  logic               cls_start, cls_done;
  gesture_e           cls_gesture;
  logic               lvl_start, lvl_done;
  logic [LEVEL_W-1:0] lvl_level;

  logic [3:0]         sb;
  logic [COORD_W-1:0] px, py;
  logic [SIZE_W:0]    x_end, y_end;
  logic               in_rect, swipe_ok, match;

  // Unpack the input transfer.
  assign in_index        = s_axis_tdata_i[3:0];
  assign in_region.x     = s_axis_tdata_i[15:4];
  assign in_region.y     = s_axis_tdata_i[27:16];
  assign in_region.w     = s_axis_tdata_i[40:28];
  assign in_region.h     = s_axis_tdata_i[53:41];
  assign in_region.flags = s_axis_tdata_i[60:54];
  assign in_down_x       = s_axis_tdata_i[72:61];
  assign in_down_y       = s_axis_tdata_i[84:73];
  assign in_lift_x       = s_axis_tdata_i[96:85];
  assign in_lift_y       = s_axis_tdata_i[108:97];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Drop stores aimed past the end of the table.
  assign wr_en = s_fire && (s_axis_tuser_i == REQ_WRITE) && ({3'b0, in_index} < MAX_R7);

  // Searched entries: the count register, capped at the table depth.
  assign n7 = ({2'b0, region_count_q} > MAX_R7) ? MAX_R7 : {2'b0, region_count_q};
  assign n  = n7[CW-1:0];

  // Configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= 5'd0;
      swipe_min_q    <= 8'd40;
      tap_max_q      <= 8'd20;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_REGION_COUNT: region_count_q <= cfg_data_i[4:0];
        CFG_SWIPE_MIN:    swipe_min_q    <= cfg_data_i;
        CFG_TAP_MAX:      tap_max_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tgrh_table #(
    .Depth (MAX_REGIONS),
    .AddrW (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(in_index)),
    .wr_data_i (in_region),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  tgrh_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cls_start),
    .down_x_i    (in_down_x),
    .down_y_i    (in_down_y),
    .lift_x_i    (in_lift_x),
    .lift_y_i    (in_lift_y),
    .swipe_min_i (swipe_min_q),
    .tap_max_i   (tap_max_q),
    .done_o      (cls_done),
    .gesture_o   (cls_gesture)
  );

  tgrh_level u_level (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lvl_start),
    .region_i (rd_data),
    .lift_x_i (x1_q),
    .lift_y_i (y1_q),
    .done_o   (lvl_done),
    .level_o  (lvl_level)
  );

  // Swipe direction as a one-hot mask matching flag bits left/right/up/down.
  always_comb begin
    case (gest_q)
      G_LEFT:  sb = 4'b0001;
      G_RIGHT: sb = 4'b0010;
      G_UP:    sb = 4'b0100;
      G_DOWN:  sb = 4'b1000;
      default: sb = 4'b0000;
    endcase
  end

  // Check the entry read last cycle: down point on the first pass,
  // lift point on the swipe retry.
  assign px       = pass_q ? x1_q : x0_q;
  assign py       = pass_q ? y1_q : y0_q;
  assign x_end    = {2'b0, rd_data.x} + {1'b0, rd_data.w};
  assign y_end    = {2'b0, rd_data.y} + {1'b0, rd_data.h};
  assign in_rect  = (px >= rd_data.x) && ({2'b0, px} < x_end) &&
                    (py >= rd_data.y) && ({2'b0, py} < y_end);
  assign swipe_ok = |(rd_data.flags[F_SWIPE_HI:F_SWIPE_LO] & sb);
  assign match    = in_rect && (pass_q ? swipe_ok :
                    (rd_data.flags[F_SLIDE] ||
                     ((gest_q == G_TAP) && rd_data.flags[F_TAP]) || swipe_ok));

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    issue_d    = issue_q;
    chk_v_d    = 1'b0;
    chk_idx_d  = chk_idx_q;
    gest_d     = gest_q;
    res_hit_d  = res_hit_q;
    res_idx_d  = res_idx_q;
    res_gest_d = res_gest_q;
    res_lvl_d  = res_lvl_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    cls_start  = 1'b0;
    lvl_start  = 1'b0;
    rd_en      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire && (s_axis_tuser_i == REQ_TOUCH)) begin
          cls_start = 1'b1;
          state_d   = S_CLS;
        end
      end
      S_CLS: begin
        if (cls_done) begin
          gest_d  = cls_gesture;
          issue_d = '0;
          pass_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Advance the read pointer; data returns next cycle.
        if (issue_q < n) begin
          rd_en     = 1'b1;
          issue_d   = issue_q + 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = issue_q[AW-1:0];
        end
        if (chk_v_q && match) begin
          res_hit_d  = 1'b1;
          res_idx_d  = chk_idx_q;
          res_gest_d = gest_q;
          res_lvl_d  = '0;
          if (!pass_q && rd_data.flags[F_SLIDE]) begin
            res_gest_d = G_SLIDE;
            lvl_start  = 1'b1;
            state_d    = S_LVL;
          end else begin
            state_d = S_EMIT;
          end
        end else if (!chk_v_q && (issue_q >= n)) begin
          if (!pass_q && (sb != 4'b0000)) begin
            pass_d  = 1'b1;
            issue_d = '0;
          end else begin
            res_hit_d  = 1'b0;
            res_idx_d  = '0;
            res_gest_d = gest_q;
            res_lvl_d  = '0;
            state_d    = S_EMIT;
          end
        end
      end
      S_LVL: begin
        if (lvl_done) begin
          res_lvl_d = lvl_level;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free.
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_tdata_d = {2'b0, res_lvl_q, res_gest_q, 4'(res_idx_q)};
          m_tuser_d = res_hit_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pass_q    <= 1'b0;
      issue_q   <= '0;
      chk_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      issue_q   <= issue_d;
      chk_v_q   <= chk_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    gest_q     <= gest_d;
    res_hit_q  <= res_hit_d;
    res_idx_q  <= res_idx_d;
    res_gest_q <= res_gest_d;
    res_lvl_q  <= res_lvl_d;
    m_tdata_q  <= m_tdata_d;
    m_tuser_q  <= m_tuser_d;
    if (s_fire) begin
      x0_q <= in_down_x;
      y0_q <= in_down_y;
      x1_q <= in_lift_x;
      y1_q <= in_lift_y;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

endmodule

@@ verif/tb_touch_gesture_region_hit.sv @@
// Self-checking testbench for touch_gesture_region_hit: stream driver, result
// monitor and a predictor of region search, gesture class and slide level.
// Depends on tgrh_pkg and the touch_gesture_region_hit RTL.
module tb_touch_gesture_region_hit;
  import tgrh_pkg::*;

  localparam int NUM_ZONES     = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int TAIL_ITEMS    = 150;     // no idling once this few items remain
  localparam int HOLD_AFTER    = 300;     // touches seen before the long output stall
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 115;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic REQ_REGION = 1'b0;
  localparam logic REQ_TOUCH  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX      = 2'd2;

  localparam logic [FLAGS_W-1:0] FL_TAP   = 1 << F_TAP;
  localparam logic [FLAGS_W-1:0] FL_LEFT  = 1 << (F_SWIPE_LO + 0);
  localparam logic [FLAGS_W-1:0] FL_RIGHT = 1 << (F_SWIPE_LO + 1);
  localparam logic [FLAGS_W-1:0] FL_UP    = 1 << (F_SWIPE_LO + 2);
  localparam logic [FLAGS_W-1:0] FL_DOWN  = 1 << (F_SWIPE_LO + 3);
  localparam logic [FLAGS_W-1:0] FL_SLIDE = 1 << F_SLIDE;
  localparam logic [FLAGS_W-1:0] FL_AXISY = 1 << F_AXIS_Y;
  localparam logic [FLAGS_W-1:0] FL_SWIPES = FL_LEFT | FL_RIGHT | FL_UP | FL_DOWN;

  // One entry of the feed: either a stream item or a register write
  typedef enum logic {OP_ITEM, OP_REG} feed_kind_e;

  typedef struct packed {
    feed_kind_e             kind;
    logic                   req;
    logic [3:0]             idx;
    logic [COORD_W-1:0]     rx, ry;
    logic [SIZE_W-1:0]      rw, rh;
    logic [FLAGS_W-1:0]     flags;
    logic [COORD_W-1:0]     dx, dy, lx, ly;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
  } touch_req_t;

  typedef struct packed {
    logic                hit;
    logic [3:0]          region;
    gesture_e            gesture;
    logic [LEVEL_W-1:0]  level;
  } touch_verdict_t;

  // DUT ports; every input starts at a known value
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i = '0;
  logic                    s_axis_tuser_i = 1'b0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                    m_axis_tuser_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  touch_gesture_region_hit #(
    .MAX_REGIONS(NUM_ZONES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the region table and the three registers.
  // The table starts at zero; the stimulus never searches an entry before it
  // was stored, so the starting contents never matter.
  // ---------------------------------------------------------------------------
  region_t          zone_tab [NUM_ZONES];
  logic [4:0]       count_reg = 5'd0;
  logic [7:0]       swipe_reg = 8'd40;
  logic [7:0]       tap_reg   = 8'd20;
  touch_verdict_t   verdicts_due [$];

  // Generation-side view, kept in step with the order of the feed
  region_t          plan_zone [NUM_ZONES];
  int               plan_swipe = 40;
  int               plan_tap   = 20;
  touch_req_t       feed_q [$];

  // Counters; touches_in and feed_tail cross processes, so they move by NBA
  int               touches_in = 0;
  logic             feed_tail = 1'b0;
  int               zone_writes = 0;
  int               reg_writes = 0;
  int               results_out = 0;
  int               hits_seen = 0;
  int               slides_seen = 0;
  int               errors = 0;
  int unsigned      cycle_cnt = 0;

  initial begin
    for (int i = 0; i < NUM_ZONES; i++) begin
      zone_tab[i] = '0;
      plan_zone[i] = '0;
    end
  end

  // Swipe when d2 >= swipe^2 (horizontal wins ties), tap when d2 < tap^2,
  // dead zone in between.
  function automatic gesture_e classify_travel(longint x0, longint y0,
                                               longint x1, longint y1);
    longint dx, dy, d2, sw, tp;
    dx = x1 - x0;
    dy = y1 - y0;
    d2 = dx * dx + dy * dy;
    sw = swipe_reg;
    tp = tap_reg;
    if (d2 >= sw * sw) begin
      if (dx * dx >= dy * dy) return (dx < 0) ? G_LEFT : G_RIGHT;
      return (dy < 0) ? G_UP : G_DOWN;
    end
    if (d2 < tp * tp) return G_TAP;
    return G_NONE;
  endfunction

  // Half-open rectangle; a zero width or height holds nothing
  function automatic bit zone_covers(region_t z, longint px, longint py);
    longint zx, zy, zw, zh;
    zx = z.x;
    zy = z.y;
    zw = z.w;
    zh = z.h;
    return px >= zx && px < zx + zw && py >= zy && py < zy + zh;
  endfunction

  // Percent along the slide axis; y counts up from the bottom edge
  function automatic logic [LEVEL_W-1:0] slide_percent(region_t z, longint lx, longint ly);
    longint zx, zy, zw, zh, v;
    zx = z.x;
    zy = z.y;
    zw = z.w;
    zh = z.h;
    if (z.flags[F_AXIS_Y]) v = (zh == 0) ? 0 : ((zy + zh - ly) * LEVEL_SCALE) / zh;
    else                   v = (zw == 0) ? 0 : ((lx - zx) * LEVEL_SCALE) / zw;
    if (v < 0) v = 0;
    if (v > LEVEL_SCALE) v = LEVEL_SCALE;
    return v[LEVEL_W-1:0];
  endfunction

  // Owner search at the down point, then a swipe retry at the lift point
  function automatic touch_verdict_t judge_touch(longint x0, longint y0,
                                                 longint x1, longint y1);
    touch_verdict_t v;
    logic [3:0] dir;
    int n;
    bit done;
    v.hit = 1'b0;
    v.region = '0;
    v.gesture = classify_travel(x0, y0, x1, y1);
    v.level = '0;
    dir = 4'b0000;
    if (v.gesture >= G_LEFT && v.gesture <= G_DOWN) dir = 4'b0001 << (v.gesture - G_LEFT);
    n = (count_reg > NUM_ZONES) ? NUM_ZONES : count_reg;
    done = 1'b0;
    for (int i = 0; i < n && !done; i++) begin
      if (zone_covers(zone_tab[i], x0, y0)) begin
        if (zone_tab[i].flags[F_SLIDE]) begin
          v.hit = 1'b1;
          v.region = i[3:0];
          v.gesture = G_SLIDE;
          v.level = slide_percent(zone_tab[i], x1, y1);
          done = 1'b1;
        end else if ((v.gesture == G_TAP && zone_tab[i].flags[F_TAP]) ||
                     (zone_tab[i].flags[F_SWIPE_HI:F_SWIPE_LO] & dir) != 0) begin
          v.hit = 1'b1;
          v.region = i[3:0];
          done = 1'b1;
        end
      end
    end
    for (int i = 0; i < n && !done && dir != 0; i++) begin
      if ((zone_tab[i].flags[F_SWIPE_HI:F_SWIPE_LO] & dir) != 0 &&
          zone_covers(zone_tab[i], x1, y1)) begin
        v.hit = 1'b1;
        v.region = i[3:0];
        done = 1'b1;
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Feed builders
  // ---------------------------------------------------------------------------
  task automatic queue_region(int idx, int x, int y, int w, int h, logic [FLAGS_W-1:0] fl);
    touch_req_t op;
    op = '0;
    op.kind = OP_ITEM;
    op.req = REQ_REGION;
    op.idx = idx[3:0];
    op.rx = x[COORD_W-1:0];
    op.ry = y[COORD_W-1:0];
    op.rw = w[SIZE_W-1:0];
    op.rh = h[SIZE_W-1:0];
    op.flags = fl;
    feed_q.push_back(op);
    plan_zone[idx] = {fl, op.rh, op.rw, op.ry, op.rx};
  endtask

  task automatic queue_touch(int x0, int y0, int x1, int y1);
    touch_req_t op;
    op = '0;
    op.kind = OP_ITEM;
    op.req = REQ_TOUCH;
    op.dx = x0[COORD_W-1:0];
    op.dy = y0[COORD_W-1:0];
    op.lx = x1[COORD_W-1:0];
    op.ly = y1[COORD_W-1:0];
    feed_q.push_back(op);
  endtask

  task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, int val);
    touch_req_t op;
    op = '0;
    op.kind = OP_REG;
    op.reg_idx = idx;
    op.reg_val = val[CFG_DATA_W-1:0];
    feed_q.push_back(op);
    if (idx == REG_SWIPE_MIN) plan_swipe = val;
    if (idx == REG_TAP_MAX)   plan_tap = val;
  endtask

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int rand_span();
    case ($urandom_range(0, 39))
      0:       return 0;                               // empty rectangle
      1, 2:    return 4096;
      3, 4, 5, 6, 7, 8: return $urandom_range(1, 4096);
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  task automatic queue_random_zone();
    int x, y;
    x = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 3000);
    y = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 3000);
    queue_region($urandom_range(0, NUM_ZONES - 1), x, y, rand_span(), rand_span(),
                 $urandom_range(0, 127));
  endtask

  // Mostly well-formed: down point inside a known region, travel picked
  // around the tap and swipe thresholds or over a wider range. The rest is plain noise.
  task automatic queue_random_touch();
    region_t z;
    int x0, y0, mag, ax, ay;
    if ($urandom_range(0, 4) == 0) begin
      queue_touch($urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      z = plan_zone[$urandom_range(0, NUM_ZONES - 1)];
      ax = (z.w == 0) ? 0 : int'(z.w) - 1;
      ay = (z.h == 0) ? 0 : int'(z.h) - 1;
      x0 = clamp_coord(int'(z.x) + int'($urandom_range(0, ax)));
      y0 = clamp_coord(int'(z.y) + int'($urandom_range(0, ay)));
      case ($urandom_range(0, 3))
        0:       mag = int'($urandom_range(0, plan_tap + 3));
        1:       mag = plan_swipe - 3 + int'($urandom_range(0, 6));
        2:       mag = int'($urandom_range(0, 600));
        default: mag = int'($urandom_range(0, 4095));
      endcase
      if (mag < 0) mag = 0;
      ax = $urandom_range(0, mag);
      ay = $urandom_range(0, mag);
      case ($urandom_range(0, 3))
        0:       ay = 0;
        1:       ax = 0;
        default: ;
      endcase
      if ($urandom_range(0, 1)) ax = -ax;
      if ($urandom_range(0, 1)) ay = -ay;
      queue_touch(x0, y0, clamp_coord(x0 + ax), clamp_coord(y0 + ay));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item or one register write at a time from feed_q. Register
  // writes wait until every result is back and the block has settled.
  // ---------------------------------------------------------------------------
  int   gap_left = 0;
  int   quiet_cycles = 0;
  int   items_driven = 0;
  bit   src_idle_on = 1'b1;

  always @(posedge clk_i) begin : feed
    touch_req_t op;
    logic nv, ncv;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      nv = s_axis_tvalid_i;
      ncv = cfg_valid_i;
      // Drop valid for the transfer that completes at this edge
      if (s_axis_tvalid_i && s_axis_tready_o) nv = 1'b0;
      if (cfg_valid_i && cfg_ready_o) ncv = 1'b0;
      if (!s_axis_tvalid_i && !cfg_valid_i && verdicts_due.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;

      if (!nv && !ncv) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (feed_q.size() != 0) begin
          op = feed_q[0];
          case (op.kind)
            OP_ITEM: begin
              void'(feed_q.pop_front());
              nv = 1'b1;
              s_axis_tuser_i <= op.req;
              s_axis_tdata_i <= {3'b000, op.ly, op.lx, op.dy, op.dx, op.flags,
                                 op.rh, op.rw, op.ry, op.rx, op.idx};
              items_driven++;
              if (items_driven % 64 == 0) src_idle_on = ($urandom_range(0, 2) != 0);
              if (src_idle_on && !feed_tail && $urandom_range(0, 2) == 0)
                gap_left = $urandom_range(1, 12);
            end
            OP_REG: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                void'(feed_q.pop_front());
                ncv = 1'b1;
                cfg_index_i <= op.reg_idx;
                cfg_data_i <= op.reg_val;
              end
            end
            default: ;
          endcase
        end
      end
      s_axis_tvalid_i <= nv;
      cfg_valid_i <= ncv;
      feed_tail <= (feed_q.size() < TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off that backs the block up
  // into its input, and steady ready over the tail of the run.
  // ---------------------------------------------------------------------------
  int   sink_cycles = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   sink_idle_on = 1'b1;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      sink_cycles++;
      if (sink_cycles % 128 == 0) sink_idle_on = ($urandom_range(0, 2) != 0);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && touches_in >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready_i <= 1'b0;
      end else if (feed_tail) begin
        m_axis_tready_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: update the predictor on each accepted transfer and check every
  // result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    touch_verdict_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_REGION_COUNT: count_reg = cfg_data_i[4:0];
          REG_SWIPE_MIN:    swipe_reg = cfg_data_i;
          REG_TAP_MAX:      tap_reg = cfg_data_i;
          default: ;
        endcase
        reg_writes++;
      end

      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (s_axis_tuser_i == REQ_TOUCH) begin
          verdicts_due.push_back(judge_touch(s_axis_tdata_i[72:61], s_axis_tdata_i[84:73],
                                             s_axis_tdata_i[96:85], s_axis_tdata_i[108:97]));
          touches_in <= touches_in + 1;
        end else begin
          // tdata[60:4] is laid out exactly as one table entry
          zone_tab[s_axis_tdata_i[3:0]] = s_axis_tdata_i[60:4];
          zone_writes++;
        end
      end

      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_out++;
        if (verdicts_due.size() == 0) begin
          $error("result with no touch outstanding: hit %0d tdata %h",
                 m_axis_tuser_o, m_axis_tdata_o);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (want.hit) hits_seen++;
          if (want.gesture == G_SLIDE) slides_seen++;
          if (m_axis_tuser_o !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser_o);
            errors++;
          end
          if (m_axis_tdata_o[3:0] !== want.region) begin
            $error("hit_region: expected %0d, got %0d", want.region, m_axis_tdata_o[3:0]);
            errors++;
          end
          if (m_axis_tdata_o[6:4] !== want.gesture) begin
            $error("gesture: expected %0d, got %0d", want.gesture, m_axis_tdata_o[6:4]);
            errors++;
          end
          if (m_axis_tdata_o[13:7] !== want.level) begin
            $error("slide_level: expected %0d, got %0d", want.level, m_axis_tdata_o[13:7]);
            errors++;
          end
        end
      end
    end
  end

  // Hard stop for a hung handshake
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             verdicts_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int cnt, sw, tp;

    // Directed: empty table, reset thresholds
    queue_touch(10, 10, 10, 10);

    // Fill every entry so that no search ever reads an unwritten one
    queue_region(0,  100,  100,    0,   50, 7'h7F);          // empty rectangle
    queue_region(1,    0,    0,  200,  200, FL_TAP);
    queue_region(2,  200,    0,  200,  200, FL_LEFT | FL_RIGHT);
    queue_region(3,  400,    0, 1000,  100, FL_SLIDE);
    queue_region(4,  400,  100,  100, 1000, FL_SLIDE | FL_AXISY);
    queue_region(5,    0, 2000,  500,  500, FL_UP | FL_DOWN);
    queue_region(6, 4095, 4095,    1,    1, FL_TAP);
    queue_region(7,    0,    0, 4096, 4096, 7'h00);          // covers all, takes nothing
    queue_region(8, 3000,    0, 1000, 1000, FL_LEFT);
    queue_region(9, 2000, 2000,  100,  100, FL_TAP | FL_RIGHT | FL_UP | FL_DOWN);
    queue_region(10, 1500, 1500, 300,  300, 7'h7F);
    queue_region(11,   0, 4000, 4095,   95, FL_DOWN);
    queue_region(12, 2500, 500,   12,   13, FL_TAP);
    queue_region(13, 1000, 3000, 700,  700, FL_SLIDE);
    queue_region(14, 3500, 3500, 500,  500, FL_SWIPES);
    queue_region(15,  100, 3900,  50,   50, FL_LEFT | FL_TAP);
    queue_reg(REG_REGION_COUNT, 16);

    queue_touch(  50,   50,   52,   51);   // tap on a tap region
    queue_touch( 250,   50,  350,   60);   // swipe right
    queue_touch( 250,   50,  150,   50);   // swipe left
    queue_touch( 100,  100,  100, 2100);   // owner refuses, lift point takes it
    queue_touch( 500,   50, 1400,   50);   // slide x, full scale
    queue_touch( 900,   50,  100,   50);   // slide x, below the left edge
    queue_touch( 450,  500,  450,  600);   // slide y, middle
    queue_touch(  50,   50,   80,   50);   // dead zone between tap and swipe
    queue_touch(4095, 4095, 4095, 4095);   // far corner
    queue_touch( 200,   50,  201,   50);   // right edge is outside
    queue_touch(3500,  500, 3400,  500);   // skips the catch-all to a later owner

    queue_reg(REG_REGION_COUNT, 31);       // count above table size
    queue_touch( 120, 3920,   60, 3920);
    queue_reg(REG_SWIPE_MIN, 0);           // zero thresholds: zero travel swipes right
    queue_reg(REG_TAP_MAX, 0);
    queue_touch(3000, 3000, 3000, 3000);
    queue_reg(REG_SWIPE_MIN, 255);
    queue_reg(REG_TAP_MAX, 255);
    queue_touch(2050, 2050, 2100, 2120);

    // Random phases, each behind a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cnt = 16; sw = 40;  tp = 20;  end
        1: begin cnt = 16; sw = 255; tp = 255; end
        2: begin cnt = 16; sw = 1;   tp = 1;   end
        3: begin cnt = 31; sw = 200; tp = 10;  end
        default: begin
          case ($urandom_range(0, 5))
            0:       cnt = 0;
            1:       cnt = 31;
            2, 3:    cnt = 16;
            default: cnt = $urandom_range(1, 16);
          endcase
          case ($urandom_range(0, 7))
            0:       sw = 1;
            1:       sw = 255;
            2:       sw = 0;
            default: sw = $urandom_range(1, 255);
          endcase
          case ($urandom_range(0, 7))
            0:       tp = 1;
            1:       tp = 255;
            2:       tp = 0;
            default: tp = $urandom_range(1, 255);
          endcase
        end
      endcase
      queue_reg(REG_REGION_COUNT, cnt);
      queue_reg(REG_SWIPE_MIN, sw);
      queue_reg(REG_TAP_MAX, tp);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 4) == 0) queue_random_zone();
        else queue_random_touch();
      end
    end

    // Reset once, released at a rising edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until the feed is spent and every result is in, then let it settle
    while (feed_q.size() != 0 || s_axis_tvalid_i || cfg_valid_i || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d touch results (%0d hits, %0d slides) after %0d region stores",
             results_out, hits_seen, slides_seen, zone_writes);
    $display("%0d register writes, one %0d-cycle output hold-off, %0d cycles",
             reg_writes, HOLD_CYCLES, cycle_cnt);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
